/* rtl/i2c_register_access_master_defines.svh */
// Assertion macros for the checker file.
`ifndef I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/i2cm_pkg.sv */
package i2cm_pkg;

   localparam int UNIT_W      = 16;
   localparam int ADDR_W      = 7;
   localparam int POLL_W      = 8;
   localparam int BYTE_W      = 8;
   localparam int SEG_IDX_W   = 4;
   localparam int BIT_CNT_W   = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
   localparam int REQ_DATA_W  = 24;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 16;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [1:0] {
      CSR_DEVICE_ADDRESS = 2'd0,
      CSR_UNIT_TICKS     = 2'd1,
      CSR_ACK_POLL_LIMIT = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [ADDR_W-1:0] device_address;
      logic [UNIT_W-1:0] unit_ticks;
      logic [POLL_W-1:0] ack_poll_limit;
   } cfg_type;

   // One tick as it travels from the front part to the engine.
   typedef struct packed {
      logic [BYTE_W-1:0] wr_data;
      logic [BYTE_W-1:0] reg_addr;
      logic              func;
      logic              cmd_valid;
      logic              sda_in;
   } item_type;

   typedef enum logic [3:0] {
      SG_END    = 4'd0,
      SG_START  = 4'd1,
      SG_TXAW   = 4'd2,
      SG_TXREG  = 4'd3,
      SG_TXDATA = 4'd4,
      SG_TXAR   = 4'd5,
      SG_ACK    = 4'd6,
      SG_RX     = 4'd7,
      SG_NACK   = 4'd8,
      SG_STOP   = 4'd9
   } seg_type;

   typedef enum logic [22:0] {
      PH_IDLE = 23'h000001,
      PH_ST1  = 23'h000002,
      PH_ST2  = 23'h000004,
      PH_ST3  = 23'h000008,
      PH_TX0  = 23'h000010,
      PH_TXB  = 23'h000020,
      PH_TXH  = 23'h000040,
      PH_TXE  = 23'h000080,
      PH_AK0  = 23'h000100,
      PH_AK1  = 23'h000200,
      PH_AK2  = 23'h000400,
      PH_AKP  = 23'h000800,
      PH_AK3  = 23'h001000,
      PH_RX0  = 23'h002000,
      PH_RX1  = 23'h004000,
      PH_RXL  = 23'h008000,
      PH_RXH  = 23'h010000,
      PH_RXE  = 23'h020000,
      PH_NK1  = 23'h040000,
      PH_NK2  = 23'h080000,
      PH_SP0  = 23'h100000,
      PH_SP1  = 23'h200000,
      PH_SP2  = 23'h400000
   } phase_type;

   // Sequence of bus segments for each transaction kind.
   function automatic seg_type plan_seg(input logic is_read,
                                        input logic [SEG_IDX_W-1:0] idx);
      seg_type s;
      s = SG_END;
      if (is_read) begin
         unique case (idx)
            4'd0: s = SG_START;
            4'd1: s = SG_TXAW;
            4'd2: s = SG_ACK;
            4'd3: s = SG_TXREG;
            4'd4: s = SG_ACK;
            4'd5: s = SG_START;
            4'd6: s = SG_TXAR;
            4'd7: s = SG_ACK;
            4'd8: s = SG_RX;
            4'd9: s = SG_NACK;
            4'd10: s = SG_STOP;
            default: s = SG_END;
         endcase
      end else begin
         unique case (idx)
            4'd0: s = SG_START;
            4'd1: s = SG_TXAW;
            4'd2: s = SG_ACK;
            4'd3: s = SG_TXREG;
            4'd4: s = SG_ACK;
            4'd5: s = SG_TXDATA;
            4'd6: s = SG_ACK;
            4'd7: s = SG_STOP;
            default: s = SG_END;
         endcase
      end
      return s;
   endfunction

endpackage

/* rtl/i2cm_front.sv */
module i2cm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sda_in [0], reg_addr [8:1], wr_data [16:9], zero above
   input  logic [i2cm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd_valid [0], func [1]
   input  logic [i2cm_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              push_valid,
   input  logic                              push_ready,
   output i2cm_pkg::item_type                push_item
);

   logic               hold_valid_ff, hold_valid_in;
   i2cm_pkg::item_type hold_item_ff;
   i2cm_pkg::item_type dec_item;
   logic               take;
   logic               push;

   always_comb begin
      dec_item.sda_in    = req_tdata[0];
      dec_item.reg_addr  = req_tdata[8:1];
      dec_item.wr_data   = req_tdata[16:9];
      dec_item.cmd_valid = req_tuser[0];
      // The function code only matters when a command is present.
      dec_item.func      = req_tuser[1] & req_tuser[0];
   end

   assign push       = hold_valid_ff & push_ready;
   assign req_tready = ~hold_valid_ff | push_ready;
   assign take       = req_tvalid & req_tready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (take) begin
         hold_valid_in = 1'b1;
      end else if (push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hold_item_ff <= dec_item;
      end
   end

   assign push_valid = hold_valid_ff;
   assign push_item  = hold_item_ff;

endmodule

/* rtl/i2cm_queue.sv */
module i2cm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  i2cm_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_en,
   output i2cm_pkg::item_type pop_item
);

   i2cm_pkg::item_type                  mem_ff [i2cm_pkg::QUEUE_DEPTH];
   logic [i2cm_pkg::QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [i2cm_pkg::QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [i2cm_pkg::QUEUE_AW:0]         count_ff, count_in;
   logic                                push;
   logic                                pop;

   assign push_ready = count_ff != (i2cm_pkg::QUEUE_AW + 1)'(i2cm_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid & push_ready;
   assign pop        = pop_en & pop_valid;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/i2cm_back.sv */
module i2cm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  i2cm_pkg::cfg_type                 cfg,
   input  logic                              item_valid,
   input  i2cm_pkg::item_type                item,
   output logic                              item_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // scl_out [0], sda_out [1], busy_res [2], done_res [3], rd_data [11:4],
   // nack [12], zero above
   output logic [i2cm_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   i2cm_pkg::phase_type                  phase_ff, phase_in;
   logic [i2cm_pkg::BIT_CNT_W-1:0]       bit_count_ff, bit_count_in;
   logic [i2cm_pkg::BYTE_W-1:0]          shift_ff, shift_in;
   logic [i2cm_pkg::UNIT_W-1:0]          delay_ff, delay_in;
   logic [i2cm_pkg::POLL_W-1:0]          poll_ff, poll_in;
   logic                                 op_read_ff, op_read_in;
   logic [i2cm_pkg::BYTE_W-1:0]          held_reg_ff, held_reg_in;
   logic [i2cm_pkg::BYTE_W-1:0]          held_data_ff, held_data_in;
   logic [i2cm_pkg::BYTE_W-1:0]          read_byte_ff, read_byte_in;
   logic                                 ack_ff, ack_in;
   logic [i2cm_pkg::SEG_IDX_W-1:0]       seg_ff, seg_in;
   logic                                 units_ff, units_in;
   logic                                 scl_q_ff, scl_q_in;
   logic                                 sda_q_ff, sda_q_in;
   logic                                 out_valid_ff, out_valid_in;
   logic [i2cm_pkg::RSP_DATA_W-1:0]      out_data_ff;

   logic                                 ent;
   logic                                 ent_two;
   i2cm_pkg::phase_type                  ent_ph;
   logic                                 start_seg;
   logic                                 done;
   logic [i2cm_pkg::UNIT_W-1:0]          reload;
   logic [i2cm_pkg::BIT_CNT_W-1:0]       bc_inc;
   logic [i2cm_pkg::RSP_DATA_W-1:0]      result;

   assign item_pop = item_valid & (~out_valid_ff | rsp_tready);

   always_comb begin
      reload = ((cfg.unit_ticks == '0) ? i2cm_pkg::UNIT_W'(1) : cfg.unit_ticks)
               - i2cm_pkg::UNIT_W'(1);
      bc_inc       = bit_count_ff + 1'b1;
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      delay_in     = delay_ff;
      poll_in      = poll_ff;
      op_read_in   = op_read_ff;
      held_reg_in  = held_reg_ff;
      held_data_in = held_data_ff;
      read_byte_in = read_byte_ff;
      ack_in       = ack_ff;
      seg_in       = seg_ff;
      units_in     = units_ff;
      scl_q_in     = scl_q_ff;
      sda_q_in     = sda_q_ff;
      ent          = 1'b0;
      ent_two      = 1'b0;
      ent_ph       = i2cm_pkg::PH_IDLE;
      start_seg    = 1'b0;
      done         = 1'b0;

      // Idle command capture, tick counting and step completion.
      if (phase_ff == i2cm_pkg::PH_IDLE) begin
         if (item.cmd_valid) begin
            op_read_in   = item.func;
            held_reg_in  = item.reg_addr;
            held_data_in = item.wr_data;
            ack_in       = 1'b0;
            seg_in       = '0;
            start_seg    = 1'b1;
         end
      end else if (delay_ff != '0) begin
         delay_in = delay_ff - 1'b1;
      end else if (units_ff) begin
         units_in = 1'b0;
         delay_in = reload;
      end else begin
         unique case (phase_ff)
            i2cm_pkg::PH_ST1: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_ST2; end
            i2cm_pkg::PH_ST2: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_ST3; end
            i2cm_pkg::PH_TX0: begin
               ent = 1'b1; ent_ph = i2cm_pkg::PH_TXB; ent_two = 1'b1;
            end
            i2cm_pkg::PH_TXB: begin
               ent = 1'b1; ent_ph = i2cm_pkg::PH_TXH; ent_two = 1'b1;
            end
            i2cm_pkg::PH_TXH: begin
               shift_in     = {shift_ff[i2cm_pkg::BYTE_W-2:0], 1'b0};
               bit_count_in = bc_inc;
               ent          = 1'b1;
               if (bc_inc >= i2cm_pkg::BIT_CNT_W'(i2cm_pkg::BYTE_W)) begin
                  ent_ph = i2cm_pkg::PH_TXE;
               end else begin
                  ent_ph  = i2cm_pkg::PH_TXB;
                  ent_two = 1'b1;
               end
            end
            i2cm_pkg::PH_AK0: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_AK1; end
            i2cm_pkg::PH_AK1: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_AK2; end
            i2cm_pkg::PH_AK2, i2cm_pkg::PH_AKP: begin
               ent = 1'b1;
               if (item.sda_in && (poll_ff < cfg.ack_poll_limit)) begin
                  poll_in = poll_ff + 1'b1;
                  ent_ph  = i2cm_pkg::PH_AKP;
                  ent_two = 1'b1;
               end else begin
                  ack_in = item.sda_in;
                  ent_ph = i2cm_pkg::PH_AK3;
               end
            end
            i2cm_pkg::PH_RX0: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_RX1; end
            i2cm_pkg::PH_RX1: begin
               ent = 1'b1; ent_ph = i2cm_pkg::PH_RXL; ent_two = 1'b1;
            end
            i2cm_pkg::PH_RXL: begin
               ent = 1'b1; ent_ph = i2cm_pkg::PH_RXH; ent_two = 1'b1;
            end
            i2cm_pkg::PH_RXH: begin
               shift_in     = {shift_ff[i2cm_pkg::BYTE_W-2:0], item.sda_in};
               bit_count_in = bc_inc;
               ent          = 1'b1;
               if (bc_inc >= i2cm_pkg::BIT_CNT_W'(i2cm_pkg::BYTE_W)) begin
                  read_byte_in = shift_in;
                  ent_ph       = i2cm_pkg::PH_RXE;
               end else begin
                  ent_ph  = i2cm_pkg::PH_RXL;
                  ent_two = 1'b1;
               end
            end
            i2cm_pkg::PH_NK1: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_NK2; end
            i2cm_pkg::PH_SP0: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_SP1; end
            i2cm_pkg::PH_SP1: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_SP2; end
            // The last step of every segment moves on to the next segment.
            default: begin
               seg_in    = seg_ff + 1'b1;
               start_seg = 1'b1;
            end
         endcase
      end

      // Segment entry: load the byte to send and pick the first step.
      if (start_seg) begin
         bit_count_in = '0;
         poll_in      = '0;
         unique case (i2cm_pkg::plan_seg(op_read_in, seg_in))
            i2cm_pkg::SG_START: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_ST1; end
            i2cm_pkg::SG_TXAW: begin
               shift_in = {cfg.device_address, 1'b0};
               ent      = 1'b1;
               ent_ph   = i2cm_pkg::PH_TX0;
            end
            i2cm_pkg::SG_TXAR: begin
               shift_in = {cfg.device_address, 1'b1};
               ent      = 1'b1;
               ent_ph   = i2cm_pkg::PH_TX0;
            end
            i2cm_pkg::SG_TXREG: begin
               shift_in = held_reg_in;
               ent      = 1'b1;
               ent_ph   = i2cm_pkg::PH_TX0;
            end
            i2cm_pkg::SG_TXDATA: begin
               shift_in = held_data_in;
               ent      = 1'b1;
               ent_ph   = i2cm_pkg::PH_TX0;
            end
            i2cm_pkg::SG_ACK: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_AK0; end
            i2cm_pkg::SG_RX: begin
               shift_in = '0;
               ent      = 1'b1;
               ent_ph   = i2cm_pkg::PH_RX0;
            end
            i2cm_pkg::SG_NACK: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_NK1; end
            i2cm_pkg::SG_STOP: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_SP0; end
            default: begin
               phase_in = i2cm_pkg::PH_IDLE;
               scl_q_in = 1'b1;
               sda_q_in = 1'b1;
               delay_in = '0;
               units_in = 1'b0;
               done     = 1'b1;
            end
         endcase
      end

      // Step entry: restart the delay and set the line levels of the step.
      if (ent) begin
         phase_in = ent_ph;
         delay_in = reload;
         units_in = ent_two;
         unique case (ent_ph)
            i2cm_pkg::PH_ST1: scl_q_in = 1'b1;
            i2cm_pkg::PH_ST2: sda_q_in = 1'b1;
            i2cm_pkg::PH_ST3: sda_q_in = 1'b0;
            i2cm_pkg::PH_TXB: begin
               scl_q_in = 1'b0;
               sda_q_in = shift_in[i2cm_pkg::BYTE_W-1];
            end
            i2cm_pkg::PH_TXH, i2cm_pkg::PH_AK2, i2cm_pkg::PH_RXH,
            i2cm_pkg::PH_SP1: scl_q_in = 1'b1;
            i2cm_pkg::PH_AK1, i2cm_pkg::PH_RX1, i2cm_pkg::PH_SP2: sda_q_in = 1'b1;
            i2cm_pkg::PH_NK1: begin
               scl_q_in = 1'b1;
               sda_q_in = 1'b1;
            end
            i2cm_pkg::PH_SP0: sda_q_in = 1'b0;
            i2cm_pkg::PH_AKP: scl_q_in = scl_q_ff;
            default: scl_q_in = 1'b0;
         endcase
      end

      result = {3'b000, ack_in, read_byte_in, done,
                phase_in != i2cm_pkg::PH_IDLE, sda_q_in, scl_q_in};
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (item_pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cm_pkg::PH_IDLE;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         delay_ff     <= '0;
         poll_ff      <= '0;
         op_read_ff   <= 1'b0;
         held_reg_ff  <= '0;
         held_data_ff <= '0;
         read_byte_ff <= '0;
         ack_ff       <= 1'b0;
         seg_ff       <= '0;
         units_ff     <= 1'b0;
         scl_q_ff     <= 1'b1;
         sda_q_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (item_pop) begin
            phase_ff     <= phase_in;
            bit_count_ff <= bit_count_in;
            shift_ff     <= shift_in;
            delay_ff     <= delay_in;
            poll_ff      <= poll_in;
            op_read_ff   <= op_read_in;
            held_reg_ff  <= held_reg_in;
            held_data_ff <= held_data_in;
            read_byte_ff <= read_byte_in;
            ack_ff       <= ack_in;
            seg_ff       <= seg_in;
            units_ff     <= units_in;
            scl_q_ff     <= scl_q_in;
            sda_q_ff     <= sda_q_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

/* rtl/i2c_register_access_master.sv */
// Throughput: one tick transfer accepted and one result returned per clock cycle
// while the result side does not stall. A tick passes the input register, the
// four-entry queue and the step engine, whose output register holds its result.
// Reset (synchronous, active high): queue empty, engine idle with both lines released,
// registers back to device_address 81, unit_ticks 50, ack_poll_limit 100.
module i2c_register_access_master (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sda_in [0], reg_addr [8:1], wr_data [16:9], zero above
   input  logic [i2cm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd_valid [0], func [1]
   input  logic [i2cm_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // scl_out [0], sda_out [1], busy_res [2], done_res [3], rd_data [11:4],
   // nack [12], zero above
   output logic [i2cm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [i2cm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [i2cm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   i2cm_pkg::cfg_type  cfg_ff, cfg_in;
   logic               csr_wr;
   logic               push_valid;
   logic               push_ready;
   i2cm_pkg::item_type push_item;
   logic               pop_valid;
   logic               pop_en;
   i2cm_pkg::item_type pop_item;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            i2cm_pkg::CSR_DEVICE_ADDRESS:
               cfg_in.device_address = csr_pwdata[i2cm_pkg::ADDR_W-1:0];
            i2cm_pkg::CSR_UNIT_TICKS:
               cfg_in.unit_ticks = csr_pwdata[i2cm_pkg::UNIT_W-1:0];
            i2cm_pkg::CSR_ACK_POLL_LIMIT:
               cfg_in.ack_poll_limit = csr_pwdata[i2cm_pkg::POLL_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         i2cm_pkg::CSR_DEVICE_ADDRESS:
            csr_prdata = i2cm_pkg::CSR_DATA_W'(cfg_ff.device_address);
         i2cm_pkg::CSR_UNIT_TICKS:
            csr_prdata = i2cm_pkg::CSR_DATA_W'(cfg_ff.unit_ticks);
         i2cm_pkg::CSR_ACK_POLL_LIMIT:
            csr_prdata = i2cm_pkg::CSR_DATA_W'(cfg_ff.ack_poll_limit);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= i2cm_pkg::ADDR_W'(81);
         cfg_ff.unit_ticks     <= i2cm_pkg::UNIT_W'(50);
         cfg_ff.ack_poll_limit <= i2cm_pkg::POLL_W'(100);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   i2cm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   i2cm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_en     (pop_en),
      .pop_item   (pop_item)
   );

   i2cm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (pop_valid),
      .item       (pop_item),
      .item_pop   (pop_en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* rtl/i2cm_checker.sv */
`include "i2c_register_access_master_defines.svh"

module i2cm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [i2cm_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   // A stalled result transfer keeps its payload.
   `I2CM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // The finishing tick already reports the bus as free.
   `I2CM_ASSERT_SAME(a_done_not_busy, clock, reset, rsp_tvalid && rsp_tdata[3], !rsp_tdata[2], "done reported while busy")

   // With no transaction running, both lines are released.
   `I2CM_ASSERT_SAME(a_idle_release, clock, reset, rsp_tvalid && !rsp_tdata[2], rsp_tdata[1:0] == 2'b11, "line driven low while idle")

endmodule

bind i2c_register_access_master i2cm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import i2cm_pkg::*;

   localparam int CSR_UNUSED_INDEX = 3;
   localparam int CYCLE_LIMIT      = 500000;
   localparam int HOLD_CYCLES      = 400;
   localparam int PRINT_LIMIT      = 30;

   // Packed so that it maps directly onto rsp_tdata[12:0].
   typedef struct packed {
      logic       nack;
      logic [7:0] rd_data;
      logic       done;
      logic       busy;
      logic       sda_out;
      logic       scl_out;
   } bus_levels_t;

   localparam seg_type WRITE_PLAN [0:15] = '{
      SG_START, SG_TXAW, SG_ACK, SG_TXREG, SG_ACK, SG_TXDATA, SG_ACK, SG_STOP,
      SG_END, SG_END, SG_END, SG_END, SG_END, SG_END, SG_END, SG_END};
   localparam seg_type READ_PLAN [0:15] = '{
      SG_START, SG_TXAW, SG_ACK, SG_TXREG, SG_ACK, SG_START, SG_TXAR, SG_ACK,
      SG_RX, SG_NACK, SG_STOP, SG_END, SG_END, SG_END, SG_END, SG_END};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   i2c_register_access_master i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Bus engine model state.
   cfg_type     model_cfg;
   phase_type   bus_phase;
   logic [3:0]  bit_cnt;
   logic [7:0]  shreg;
   logic [15:0] unit_delay;
   logic [7:0]  polls;
   logic        rd_op;
   logic [7:0]  cmd_reg;
   logic [7:0]  cmd_data;
   logic [7:0]  last_rd;
   logic        ack_level;
   logic [3:0]  seg_pos;
   logic        extra_unit;
   logic        scl_line;
   logic        sda_line;
   logic        done_pulse;

   item_type    pending_ticks[$];
   bus_levels_t expected_lines[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   logic        req_taken = 1'b0;
   logic        hold_request = 1'b0;

   function automatic void reset_bus_model();
      model_cfg.device_address = 7'd81;
      model_cfg.unit_ticks     = 16'd50;
      model_cfg.ack_poll_limit = 8'd100;
      bus_phase  = PH_IDLE;
      bit_cnt    = '0;
      shreg      = '0;
      unit_delay = '0;
      polls      = '0;
      rd_op      = 1'b0;
      cmd_reg    = '0;
      cmd_data   = '0;
      last_rd    = '0;
      ack_level  = 1'b0;
      seg_pos    = '0;
      extra_unit = 1'b0;
      scl_line   = 1'b1;
      sda_line   = 1'b1;
      done_pulse = 1'b0;
   endfunction

   function automatic logic [15:0] unit_span();
      return (model_cfg.unit_ticks == '0) ? 16'd1 : model_cfg.unit_ticks;
   endfunction

   function automatic void enter_phase(phase_type ph, logic two_units);
      bus_phase  = ph;
      unit_delay = unit_span() - 16'd1;
      extra_unit = two_units;
      case (ph)
         PH_ST1: scl_line = 1'b1;
         PH_ST2: sda_line = 1'b1;
         PH_ST3: sda_line = 1'b0;
         PH_TXB: begin
            scl_line = 1'b0;
            sda_line = shreg[7];
         end
         PH_TXH, PH_AK2, PH_RXH, PH_SP1: scl_line = 1'b1;
         PH_AK1, PH_RX1, PH_SP2: sda_line = 1'b1;
         PH_NK1: begin
            scl_line = 1'b1;
            sda_line = 1'b1;
         end
         PH_SP0: sda_line = 1'b0;
         PH_AKP: ;
         default: scl_line = 1'b0;
      endcase
   endfunction

   function automatic void open_segment();
      seg_type s;
      s = rd_op ? READ_PLAN[seg_pos] : WRITE_PLAN[seg_pos];
      bit_cnt = '0;
      polls   = '0;
      case (s)
         SG_START: enter_phase(PH_ST1, 1'b0);
         SG_TXAW: begin
            shreg = {model_cfg.device_address, 1'b0};
            enter_phase(PH_TX0, 1'b0);
         end
         SG_TXAR: begin
            shreg = {model_cfg.device_address, 1'b1};
            enter_phase(PH_TX0, 1'b0);
         end
         SG_TXREG: begin
            shreg = cmd_reg;
            enter_phase(PH_TX0, 1'b0);
         end
         SG_TXDATA: begin
            shreg = cmd_data;
            enter_phase(PH_TX0, 1'b0);
         end
         SG_ACK: enter_phase(PH_AK0, 1'b0);
         SG_RX: begin
            shreg = '0;
            enter_phase(PH_RX0, 1'b0);
         end
         SG_NACK: enter_phase(PH_NK1, 1'b0);
         SG_STOP: enter_phase(PH_SP0, 1'b0);
         default: begin
            bus_phase  = PH_IDLE;
            scl_line   = 1'b1;
            sda_line   = 1'b1;
            unit_delay = '0;
            extra_unit = 1'b0;
            done_pulse = 1'b1;
         end
      endcase
   endfunction

   function automatic void close_phase(logic sda);
      case (bus_phase)
         PH_ST1: enter_phase(PH_ST2, 1'b0);
         PH_ST2: enter_phase(PH_ST3, 1'b0);
         PH_TX0: enter_phase(PH_TXB, 1'b1);
         PH_TXB: enter_phase(PH_TXH, 1'b1);
         PH_TXH: begin
            shreg   = shreg << 1;
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) enter_phase(PH_TXE, 1'b0);
            else enter_phase(PH_TXB, 1'b1);
         end
         PH_AK0: enter_phase(PH_AK1, 1'b0);
         PH_AK1: enter_phase(PH_AK2, 1'b0);
         PH_AK2, PH_AKP: begin
            // Keep polling while the target leaves the line released.
            if (sda && polls < model_cfg.ack_poll_limit) begin
               polls = polls + 8'd1;
               enter_phase(PH_AKP, 1'b1);
            end else begin
               ack_level = sda;
               enter_phase(PH_AK3, 1'b0);
            end
         end
         PH_RX0: enter_phase(PH_RX1, 1'b0);
         PH_RX1: enter_phase(PH_RXL, 1'b1);
         PH_RXL: enter_phase(PH_RXH, 1'b1);
         PH_RXH: begin
            shreg   = {shreg[6:0], sda};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) begin
               last_rd = shreg;
               enter_phase(PH_RXE, 1'b0);
            end else begin
               enter_phase(PH_RXL, 1'b1);
            end
         end
         PH_NK1: enter_phase(PH_NK2, 1'b0);
         PH_SP0: enter_phase(PH_SP1, 1'b0);
         PH_SP1: enter_phase(PH_SP2, 1'b0);
         default: begin
            seg_pos = seg_pos + 4'd1;
            open_segment();
         end
      endcase
   endfunction

   function automatic bus_levels_t advance_bus_model(item_type t);
      bus_levels_t r;
      done_pulse = 1'b0;
      if (bus_phase == PH_IDLE) begin
         if (t.cmd_valid) begin
            rd_op     = t.func;
            cmd_reg   = t.reg_addr;
            cmd_data  = t.wr_data;
            ack_level = 1'b0;
            seg_pos   = '0;
            open_segment();
         end
      end else if (unit_delay != '0) begin
         unit_delay = unit_delay - 16'd1;
      end else if (extra_unit) begin
         extra_unit = 1'b0;
         unit_delay = unit_span() - 16'd1;
      end else begin
         close_phase(t.sda_in);
      end
      r.scl_out = scl_line;
      r.sda_out = sda_line;
      r.busy    = (bus_phase != PH_IDLE);
      r.done    = done_pulse;
      r.rd_data = last_rd;
      r.nack    = ack_level;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (mismatch_count < PRINT_LIMIT)
         $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Sender: bursts of tick transfers separated by random gaps.
   int unsigned burst_left = 1;
   int unsigned gap_left = 0;

   always @(negedge clock) begin : sender
      item_type t;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_ticks.size() != 0) begin
            t = pending_ticks.pop_front();
            req_tdata  <= REQ_DATA_W'({t.wr_data, t.reg_addr, t.sda_in});
            req_tuser  <= {t.func, t.cmd_valid};
            req_tvalid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: free-flowing stretches, random stalls, and one long hold-off.
   int unsigned rx_cycles = 0;
   int unsigned hold_left = 0;
   logic        hold_taken = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycles++;
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_cycles[8]) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   always @(posedge clock) begin : monitor
      item_type    t;
      bus_levels_t seen;
      bus_levels_t want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            t.sda_in    = req_tdata[0];
            t.reg_addr  = req_tdata[8:1];
            t.wr_data   = req_tdata[16:9];
            t.cmd_valid = req_tuser[0];
            t.func      = req_tuser[1];
            expected_lines.push_back(advance_bus_model(t));
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[12:0];
            if (expected_lines.size() == 0) begin
               report_mismatch("unexpected result transfer", 32'(seen), 0);
            end else begin
               want = expected_lines.pop_front();
               if (seen.scl_out !== want.scl_out)
                  report_mismatch("scl_out", 32'(seen.scl_out), 32'(want.scl_out));
               if (seen.sda_out !== want.sda_out)
                  report_mismatch("sda_out", 32'(seen.sda_out), 32'(want.sda_out));
               if (seen.busy !== want.busy)
                  report_mismatch("busy_res", 32'(seen.busy), 32'(want.busy));
               if (seen.done !== want.done)
                  report_mismatch("done_res", 32'(seen.done), 32'(want.done));
               if (seen.rd_data !== want.rd_data)
                  report_mismatch("rd_data", 32'(seen.rd_data), 32'(want.rd_data));
               if (seen.nack !== want.nack)
                  report_mismatch("nack", 32'(seen.nack), 32'(want.nack));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic queue_tick(input logic sda, input logic cmd, input logic func,
                             input logic [7:0] reg_addr, input logic [7:0] wr_data);
      item_type t;
      t.sda_in    = sda;
      t.cmd_valid = cmd;
      t.func      = func;
      t.reg_addr  = reg_addr;
      t.wr_data   = wr_data;
      pending_ticks.push_back(t);
   endtask

   task automatic queue_random(input int n, input int cmd_pct, input int sda_pct);
      for (int i = 0; i < n; i++)
         queue_tick($urandom_range(0, 99) < sda_pct, $urandom_range(0, 99) < cmd_pct,
                    1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
   endtask

   task automatic csr_write(input int idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * idx);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_DEVICE_ADDRESS: model_cfg.device_address = value[ADDR_W-1:0];
         CSR_UNIT_TICKS:     model_cfg.unit_ticks     = value[UNIT_W-1:0];
         CSR_ACK_POLL_LIMIT: model_cfg.ack_poll_limit = value[POLL_W-1:0];
         default: ;
      endcase
   endtask

   // Waits until every queued tick has gone through and its result has come back.
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_tvalid || expected_lines.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Feeds plain ticks until the engine ends its transaction, at most 60 rounds.
   task automatic run_to_idle();
      int rounds;
      rounds = 0;
      wait_quiet();
      while (bus_phase != PH_IDLE && rounds < 60) begin
         queue_random(50, 0, 50);
         wait_quiet();
         rounds++;
      end
   endtask

   initial begin
      reset_bus_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Under reset settings: a write starts and a second command is ignored.
      queue_tick(1'b1, 1'b0, 1'b0, 8'h00, 8'h00);
      queue_tick(1'b0, 1'b1, 1'b0, 8'hFF, 8'h00);
      queue_tick(1'b1, 1'b1, 1'b1, 8'h00, 8'hFF);
      wait_quiet();

      // Settings change while that write is still on the bus.
      csr_write(CSR_UNIT_TICKS, 32'd0);
      csr_write(CSR_ACK_POLL_LIMIT, 32'd0);
      csr_write(CSR_DEVICE_ADDRESS, 32'd0);
      csr_write(CSR_UNUSED_INDEX, 32'hFFFF_FFFF);
      run_to_idle();

      // Read with no target answering, then an acknowledged write and read.
      queue_tick(1'b1, 1'b1, 1'b1, 8'h00, 8'hFF);
      queue_random(200, 0, 100);
      run_to_idle();
      queue_tick(1'b0, 1'b1, 1'b0, 8'h00, 8'hFF);
      queue_random(150, 0, 0);
      run_to_idle();
      queue_tick(1'b0, 1'b1, 1'b1, 8'hFF, 8'h00);
      queue_random(200, 0, 0);
      run_to_idle();

      queue_random(100, 6, 50);
      run_to_idle();

      csr_write(CSR_UNIT_TICKS, 32'd1);
      csr_write(CSR_ACK_POLL_LIMIT, 32'd255);
      csr_write(CSR_DEVICE_ADDRESS, 32'd127);
      hold_request = 1'b1;
      queue_random(120, 5, 70);
      run_to_idle();

      csr_write(CSR_UNIT_TICKS, 32'd3);
      csr_write(CSR_ACK_POLL_LIMIT, 32'd2);
      csr_write(CSR_DEVICE_ADDRESS, $urandom_range(0, 127));
      queue_random(80, 4, 40);
      run_to_idle();

      csr_write(CSR_UNIT_TICKS, 32'd2);
      csr_write(CSR_ACK_POLL_LIMIT, $urandom_range(0, 8));
      csr_write(CSR_DEVICE_ADDRESS, $urandom_range(0, 127));
      queue_random(80, 5, 50);
      run_to_idle();

      // Longest unit: the transaction started here does not finish in this run.
      csr_write(CSR_UNIT_TICKS, 32'd65535);
      csr_write(CSR_ACK_POLL_LIMIT, 32'd100);
      csr_write(CSR_DEVICE_ADDRESS, 32'd81);
      queue_random(80, 3, 50);
      wait_quiet();

      repeat (20) @(negedge clock);
      if (expected_lines.size() != 0)
         report_mismatch("leftover expected results", expected_lines.size(), 0);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* i2c_register_access_master.f */
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_front.sv
rtl/i2cm_queue.sv
rtl/i2cm_back.sv
rtl/i2c_register_access_master.sv
rtl/i2cm_checker.sv
dv/tb_top.sv
